/* design/lsc_pkg.sv */
// Shared widths, register reset values and payload types of the line sensor centroid.
package lsc_pkg;

  localparam int NUM_SENSORS  = 8;
  localparam int SAMPLE_W     = 10;
  localparam int WEIGHT_W     = 8;
  localparam int FRAC_BITS    = 8;
  localparam int POS_W        = 16;

  localparam int SENSOR_IDX_W = $clog2(NUM_SENSORS);
  localparam int PROD_W       = SAMPLE_W + WEIGHT_W;
  localparam int SUM_W        = PROD_W + SENSOR_IDX_W;
  localparam int MAG_W        = SUM_W - 1;
  localparam int SUMV_W       = SAMPLE_W + SENSOR_IDX_W;
  localparam int QUOT_W       = WEIGHT_W + FRAC_BITS;
  localparam int NUM_W        = MAG_W + FRAC_BITS;
  localparam int EXT_W        = QUOT_W + POS_W;
  localparam int NUM_STAGES   = QUOT_W + 4;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  localparam sample_t LIGHT_LEVEL = SAMPLE_W'(250);

  localparam logic [EXT_W-1:0] POS_MAX_MAG = EXT_W'(2 ** (POS_W - 1) - 1);
  localparam logic [EXT_W-1:0] POS_MIN_MAG = EXT_W'(2 ** (POS_W - 1));
  localparam logic signed [POS_W-1:0] POS_HI = POS_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [POS_W-1:0] POS_LO = POS_W'(2 ** (POS_W - 1));

  localparam weight_t WEIGHT_RESET [NUM_SENSORS] = '{
    -8'sd50, -8'sd35, -8'sd15, -8'sd5, 8'sd5, 8'sd15, 8'sd35, 8'sd50
  };

  typedef struct packed {
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;
    sample_t sample_7;
  } frame_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    no_signal;
    logic                    all_light;
  } result_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    sample_t                  inv;
    logic                     light;
  } lane_t;

  typedef struct packed {
    logic [SUMV_W-1:0] rem;
    logic [QUOT_W-1:0] bits;
    logic [QUOT_W-1:0] quot;
    logic [SUMV_W-1:0] divisor;
    logic              neg;
    logic              no_signal;
    logic              all_light;
  } div_t;

endpackage

/* design/lsc_lane.sv */
// One sensor lane: inversion, weight multiply and light-level compare, registered.
module lsc_lane (
  input  logic             clk,
  input  logic             adv,
  input  lsc_pkg::sample_t sample,
  input  lsc_pkg::weight_t weight,
  output lsc_pkg::lane_t   lane
);
  import lsc_pkg::*;

  sample_t                  inv;
  logic signed [PROD_W-1:0] inv_s;
  logic signed [PROD_W-1:0] weight_s;
  logic signed [PROD_W-1:0] prod;

  assign inv      = ~sample;
  assign inv_s    = PROD_W'($signed({1'b0, inv}));
  assign weight_s = PROD_W'(weight);
  assign prod     = inv_s * weight_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      lane.prod  <= prod;
      lane.inv   <= inv;
      lane.light <= (sample <= LIGHT_LEVEL);
    end
  end

endmodule

/* design/lsc_merge.sv */
// Merge of the lane results: sums, crossing flag, then magnitude and divider setup.
module lsc_merge (
  input  logic           clk,
  input  logic           adv_sum,
  input  logic           adv_abs,
  input  lsc_pkg::lane_t lanes [lsc_pkg::NUM_SENSORS],
  output lsc_pkg::div_t  dout
);
  import lsc_pkg::*;

  logic signed [SUM_W-1:0] sum_w;
  logic signed [SUM_W-1:0] sum_w_next;
  logic [SUMV_W-1:0]       sum_v;
  logic [SUMV_W-1:0]       sum_v_next;
  logic                    light;
  logic                    light_next;
  logic [MAG_W-1:0]        mag;
  logic [NUM_W-1:0]        num;
  div_t                    dout_next;

  always_comb begin
    sum_w_next = '0;
    sum_v_next = '0;
    light_next = 1'b1;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sum_w_next = sum_w_next + SUM_W'($signed(lanes[i].prod));
      sum_v_next = sum_v_next + SUMV_W'(lanes[i].inv);
      light_next = light_next & lanes[i].light;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_sum) begin
      sum_w <= sum_w_next;
      sum_v <= sum_v_next;
      light <= light_next;
    end
  end

  // quotient fits QUOT_W bits, so the bits above it start out as the remainder
  always_comb begin
    mag = sum_w[SUM_W-1] ? MAG_W'(-sum_w) : MAG_W'(sum_w);
    num = NUM_W'(mag) << FRAC_BITS;
    dout_next.rem       = SUMV_W'(num[NUM_W-1:QUOT_W]);
    dout_next.bits      = num[QUOT_W-1:0];
    dout_next.quot      = '0;
    dout_next.divisor   = sum_v;
    dout_next.neg       = sum_w[SUM_W-1];
    dout_next.no_signal = (sum_v == '0);
    dout_next.all_light = light;
  end

  always_ff @(posedge clk) begin
    if (adv_abs) begin
      dout <= dout_next;
    end
  end

endmodule

/* design/lsc_div_stage.sv */
// One restoring-division stage: produces one quotient bit per cycle while adv is high.
module lsc_div_stage (
  input  logic          clk,
  input  logic          adv,
  input  lsc_pkg::div_t din,
  output lsc_pkg::div_t dout
);
  import lsc_pkg::*;

  logic [SUMV_W+1:0] partial;
  logic [SUMV_W+1:0] trial;
  logic              fits;
  div_t              dout_next;

  always_comb begin
    partial = (SUMV_W+2)'({din.rem, din.bits[QUOT_W-1]});
    trial   = partial - (SUMV_W+2)'(din.divisor);
    fits    = !trial[SUMV_W+1];
    dout_next           = din;
    dout_next.rem       = fits ? trial[SUMV_W-1:0] : partial[SUMV_W-1:0];
    dout_next.bits      = din.bits << 1;
    dout_next.quot      = {din.quot[QUOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

/* design/line_sensor_centroid.sv */
// Top level of the line sensor centroid: weight registers, lanes, merge, divider, output.
//
// Takes one frame of eight 10-bit readings per cycle unless frame_stall is high, and
// returns its weighted centroid, no-signal and crossing flags. The divider is a pipeline
// of one restoring stage per quotient bit; eight multiplier lanes, two merge stages and an
// output register make up the rest. Each stage advances when it is empty or the stage
// after it moves, so bubbles close up while the output is stalled. Weights are written
// through the wr_en/wr_index/wr_data port and should only change while no frame is in
// flight.
module line_sensor_centroid (
  input  logic                                clk,
  input  logic                                rst,
  input  lsc_pkg::frame_t                     frame,
  input  logic                                frame_valid,
  output logic                                frame_stall,
  output lsc_pkg::result_t                    result,
  output logic                                result_valid,
  input  logic                                result_stall,
  input  logic                                wr_en,
  input  logic [lsc_pkg::SENSOR_IDX_W-1:0]    wr_index,
  input  logic [lsc_pkg::WEIGHT_W-1:0]        wr_data
);
  import lsc_pkg::*;

  localparam int ST_LANE = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_ABS  = 2;
  localparam int ST_DIV  = 3;
  localparam int ST_OUT  = NUM_STAGES - 1;

  weight_t weights [NUM_SENSORS];
  sample_t samples [NUM_SENSORS];
  lane_t   lanes   [NUM_SENSORS];
  div_t    div_pipe [QUOT_W+1];

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  logic [EXT_W-1:0]        quot_ext;
  logic signed [POS_W-1:0] quot_pos;
  result_t                 result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= WEIGHT_RESET;
    end else if (wr_en) begin
      weights[wr_index] <= weight_t'(wr_data);
    end
  end

  assign samples[0] = frame.sample_0;
  assign samples[1] = frame.sample_1;
  assign samples[2] = frame.sample_2;
  assign samples[3] = frame.sample_3;
  assign samples[4] = frame.sample_4;
  assign samples[5] = frame.sample_5;
  assign samples[6] = frame.sample_6;
  assign samples[7] = frame.sample_7;

  // flow control
  assign adv[ST_OUT] = !vld[ST_OUT] || !result_stall;
  for (genvar k = 0; k < ST_OUT; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[ST_LANE]) begin
        vld[ST_LANE] <= frame_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign frame_stall  = !adv[ST_LANE];
  assign result_valid = vld[ST_OUT];

  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    lsc_lane u_lane (
      .clk    (clk),
      .adv    (adv[ST_LANE]),
      .sample (samples[i]),
      .weight (weights[i]),
      .lane   (lanes[i])
    );
  end

  lsc_merge u_merge (
    .clk     (clk),
    .adv_sum (adv[ST_SUM]),
    .adv_abs (adv[ST_ABS]),
    .lanes   (lanes),
    .dout    (div_pipe[0])
  );

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    lsc_div_stage u_div_stage (
      .clk  (clk),
      .adv  (adv[ST_DIV+k]),
      .din  (div_pipe[k]),
      .dout (div_pipe[k+1])
    );
  end

  // sign and saturation
  always_comb begin
    quot_ext  = EXT_W'(div_pipe[QUOT_W].quot);
    quot_pos  = POS_W'(div_pipe[QUOT_W].quot);
    result_next.no_signal = div_pipe[QUOT_W].no_signal;
    result_next.all_light = div_pipe[QUOT_W].all_light;
    if (div_pipe[QUOT_W].no_signal) begin
      result_next.position = '0;
    end else if (div_pipe[QUOT_W].neg) begin
      result_next.position = (quot_ext > POS_MIN_MAG) ? POS_LO : -quot_pos;
    end else begin
      result_next.position = (quot_ext > POS_MAX_MAG) ? POS_HI : quot_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      result <= result_next;
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for line_sensor_centroid: directed table, then random frames under several weight sets and flow-control mixes.
module tb_top;
  import lsc_pkg::*;

  typedef struct packed {
    frame_t  frm;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 230;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_REPORTS  = 10;
  localparam longint FULL_SCALE = 2 ** SAMPLE_W - 1;

  localparam sample_t EDGE_VALUES [5] = '{10'd0, 10'd250, 10'd251, 10'd1022, 10'd1023};

  // typed rows use the reset weights
  localparam dir_row_t DIRECTED_ROWS [18] = '{
    '{{8{10'd1023}}, 1'b1, '{16'sd0, 1'b1, 1'b0}},
    '{{8{10'd0}}, 1'b1, '{16'sd0, 1'b0, 1'b1}},
    '{{8{10'd250}}, 1'b1, '{16'sd0, 1'b0, 1'b1}},
    '{{8{10'd251}}, 1'b1, '{16'sd0, 1'b0, 1'b0}},
    '{{10'd0, {7{10'd1023}}}, 1'b1, '{-16'sd12800, 1'b0, 1'b0}},
    '{{{7{10'd1023}}, 10'd0}, 1'b1, '{16'sd12800, 1'b0, 1'b0}},
    '{{{3{10'd1023}}, 10'd0, {4{10'd1023}}}, 1'b1, '{-16'sd1280, 1'b0, 1'b0}},
    '{{{4{10'd1023}}, 10'd0, {3{10'd1023}}}, 1'b1, '{16'sd1280, 1'b0, 1'b0}},
    '{{10'd1022, {7{10'd1023}}}, 1'b1, '{-16'sd12800, 1'b0, 1'b0}},
    '{{{7{10'd1023}}, 10'd1022}, 1'b1, '{16'sd12800, 1'b0, 1'b0}},
    '{{10'd0, {6{10'd1023}}, 10'd0}, 1'b1, '{16'sd0, 1'b0, 1'b0}},
    '{{4{10'd0, 10'd1023}}, 1'b0, '0},
    '{{10'd250, {7{10'd0}}}, 1'b0, '0},
    '{{4{10'h2AA, 10'h155}}, 1'b0, '0},
    '{{10'd1023, 10'd0, 10'd0, {5{10'd1023}}}, 1'b0, '0},
    '{{{6{10'd1023}}, 10'd1022, 10'd1023}, 1'b0, '0},
    '{{10'd251, {7{10'd0}}}, 1'b0, '0},
    '{{8{10'd512}}, 1'b0, '0}
  };

  logic                    clk;
  logic                    rst          = 1'b1;
  frame_t                  frame        = '0;
  logic                    frame_valid  = 1'b0;
  logic                    frame_stall;
  result_t                 result;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic                    wr_en        = 1'b0;
  logic [SENSOR_IDX_W-1:0] wr_index     = '0;
  logic [WEIGHT_W-1:0]     wr_data      = '0;

  weight_t weights [NUM_SENSORS];
  result_t pending_results [$];
  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  int      mismatches    = 0;

  line_sensor_centroid u_top (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic result_t centroid_of(frame_t f);
    longint  wsum;
    longint  vsum;
    longint  inv;
    longint  q;
    logic    light;
    sample_t s;
    result_t r;
    wsum  = 0;
    vsum  = 0;
    q     = 0;
    light = 1'b1;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      s = f[(NUM_SENSORS-1-i)*SAMPLE_W +: SAMPLE_W];
      inv = FULL_SCALE - longint'(s);
      wsum += inv * longint'(weights[i]);
      vsum += inv;
      if (s > LIGHT_LEVEL) light = 1'b0;
    end
    if (vsum != 0) begin
      // SV integer division truncates toward zero
      q = (wsum * (longint'(1) << FRAC_BITS)) / vsum;
      if (q > longint'(POS_HI)) q = longint'(POS_HI);
      if (q < longint'(POS_LO)) q = longint'(POS_LO);
    end
    r.position  = POS_W'(q);
    r.no_signal = (vsum == 0);
    r.all_light = light;
    return r;
  endfunction

  task automatic send_frame(frame_t f, logic typed, result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame       <= f;
    frame_valid <= 1'b1;
    do @(posedge clk); while (frame_stall);
    pending_results.push_back(typed ? want : centroid_of(f));
  endtask

  task automatic drain(int settle);
    frame_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transaction: position=%0d no_signal=%0b all_light=%0b",
                   result.position, result.no_signal, result.all_light);
      end else begin
        want = pending_results.pop_front();
        if (result.position !== want.position || result.no_signal !== want.no_signal ||
            result.all_light !== want.all_light) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: position exp %0d got %0d, no_signal exp %0b got %0b, all_light exp %0b got %0b",
                     want.position, result.position, want.no_signal, result.no_signal,
                     want.all_light, result.all_light);
        end
      end
    end
  end

  initial begin
    frame_t  f;
    sample_t s;
    weight_t w;
    int      mode;
    int      first;
    int      width;
    weights = WEIGHT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[k])
      send_frame(DIRECTED_ROWS[k].frm, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

    for (int p = 0; p < N_PHASES; p++) begin
      drain(DRAIN_CYCLES);
      send_idle_pct = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 34 : 0;
      stall_pct     = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 34 : 0;
      if (p != 0) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          case (p)
            1:       w = weight_t'(-128);
            2:       w = weight_t'(127);
            4:       w = (i % 2) ? weight_t'(127) : weight_t'(-128);
            7:       w = WEIGHT_RESET[i];
            default: w = weight_t'($urandom_range(255));
          endcase
          wr_en    <= 1'b1;
          wr_index <= SENSOR_IDX_W'(i);
          wr_data  <= w;
          weights[i] = w;
          @(posedge clk);
        end
        wr_en <= 1'b0;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 3 && n == PHASE_ITEMS / 2) || $urandom_range(199) == 0) drain(0);
        mode  = $urandom_range(9);
        first = $urandom_range(NUM_SENSORS - 1);
        width = $urandom_range(3, 1);
        for (int i = 0; i < NUM_SENSORS; i++) begin
          case (mode)
            3, 4: s = (i >= first && i < first + width) ? sample_t'($urandom_range(400))
                                                        : sample_t'($urandom_range(1023, 900));
            5: s = (i == first && width == 1) ? sample_t'($urandom_range(260, 251))
                                              : sample_t'($urandom_range(250));
            6: s = (i == first && width == 1) ? sample_t'($urandom_range(1023, 1000))
                                              : sample_t'(FULL_SCALE);
            7: s = EDGE_VALUES[$urandom_range(4)];
            default: s = sample_t'($urandom_range(1023));
          endcase
          f[(NUM_SENSORS-1-i)*SAMPLE_W +: SAMPLE_W] = s;
        end
        send_frame(f, 1'b0, '0);
      end
    end

    drain(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lsc_pkg.sv
design/lsc_lane.sv
design/lsc_merge.sv
design/lsc_div_stage.sv
design/line_sensor_centroid.sv
tb/tb_top.sv
